[src/dfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dfd_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ENTRY_AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_WINDOW    = 2'd2;

    localparam logic [15:0] THRESHOLD_RESET = 16'd20;
    localparam logic [15:0] WINDOW_RESET    = 16'd1000;

    localparam logic [15:0] FRAME_MIN_LEN = 16'd24;
    localparam logic [1:0]  TYPE_MGMT     = 2'd0;
    localparam logic [3:0]  SUB_DEAUTH    = 4'd12;
    localparam logic [3:0]  SUB_DISASSOC  = 4'd10;

    typedef struct packed {
        logic [47:0] bssid;
        logic [31:0] hits;
        logic [15:0] window_hits;
        logic        flood;
        logic [31:0] first_seen;
        logic [31:0] last_seen;
    } t_entry;

    typedef struct packed {
        t_entry entry;
        logic   raised;
        logic   match;
    } t_alu_res;

endpackage

`default_nettype wire

[src/dfd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/dfd_entry_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module dfd_entry_alu (
    input  wire dfd_pkg::t_entry   i_entry,
    input  wire logic              i_roll,
    input  wire logic [15:0]       i_threshold,
    input  wire logic [31:0]       i_time,
    input  wire logic [47:0]       i_bssid,
    output dfd_pkg::t_alu_res      o_res
);

    logic [15:0] wh_inc;

    always_comb begin
        wh_inc = (i_entry.window_hits != '1) ? i_entry.window_hits + 16'd1
                                             : i_entry.window_hits;
        o_res       = '0;
        o_res.entry = i_entry;
        o_res.match = (i_entry.bssid == i_bssid);
        if (i_roll) begin
            // end of window: keep the flag only if the window reached the threshold
            o_res.entry.flood       = i_entry.flood && (i_entry.window_hits >= i_threshold);
            o_res.entry.window_hits = '0;
        end else begin
            o_res.entry.hits        = (i_entry.hits != '1) ? i_entry.hits + 32'd1
                                                           : i_entry.hits;
            o_res.entry.window_hits = wh_inc;
            o_res.entry.last_seen   = i_time;
            o_res.raised            = !i_entry.flood && (wh_inc >= i_threshold);
            o_res.entry.flood       = i_entry.flood || o_res.raised;
        end
    end

endmodule

`default_nettype wire

[src/deauth_flood_detector_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Deauthentication / disassociation flood detector. Issue one operation per start pulse
// (frame header, millisecond tick, or table read) while busy is low; each operation returns
// exactly one result, shown for a single cycle with o_valid, which cannot be stalled.
// Ignored frames, ticks that do not end a window, out-of-range reads and unused opcodes
// answer in the cycle after start without raising busy. A table read answers via the read
// state; a counted frame walks the table in the scan state and updates in the update state;
// a window roll walks it in the roll state. Walks read the entries in use (at most 16)
// from memory, one entry per cycle, by one shared update/compare unit. Configuration writes
// take effect at once and should only be made while busy is low and no result is pending.
module deauth_flood_detector_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_frame_control,
    input  wire logic [15:0] i_frame_length,
    input  wire logic [47:0] i_bssid_in,
    input  wire logic [7:0]  i_read_index,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_valid,
    output logic             o_entry_valid,
    output logic [47:0]      o_bssid_out,
    output logic [31:0]      o_hit_count,
    output logic [15:0]      o_window_hits,
    output logic             o_entry_flooding,
    output logic [31:0]      o_first_seen_ms,
    output logic [31:0]      o_last_seen_ms,
    output logic             o_became_flood,
    output logic             o_any_flooding,
    output logic [8:0]       o_entries_used,
    output logic [31:0]      o_frames_total
);

    localparam int AW = dfd_pkg::ENTRY_AW;
    localparam int CW = dfd_pkg::CNT_W;
    localparam int EW = $bits(dfd_pkg::t_entry);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_ROLL = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;

    logic [2:0]  r_state;
    logic        r_enable;
    logic [15:0] r_thr;
    logic [15:0] r_wlen;
    logic [CW-1:0] r_used;
    logic [31:0] r_total;
    logic        r_flood_any;
    logic [31:0] r_time;
    logic [15:0] r_elapsed;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_cidx;
    logic [AW-1:0] r_hit;
    logic        r_pend;
    logic        r_any;
    logic [47:0] r_bssid;
    dfd_pkg::t_entry r_ent;

    logic        r_valid;
    logic        r_res_ev;
    logic        r_res_bf;
    dfd_pkg::t_entry r_res_entry;

    logic [EW-1:0] ram_rdata;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [AW-1:0] ram_waddr;
    logic          ram_we;

    dfd_pkg::t_entry   alu_in;
    dfd_pkg::t_alu_res alu_res;

    logic [8:0]  rd_off;
    logic        rd_hit;
    logic        qualify;
    logic [15:0] elapsed_inc;
    logic        issue;
    logic        any_next;
    dfd_pkg::t_entry fresh;

    always_comb begin
        rd_off  = 9'(r_used) - 9'd1 - {1'b0, i_read_index};
        rd_hit  = {1'b0, i_read_index} < 9'(r_used);
        qualify = r_enable && (i_frame_length >= dfd_pkg::FRAME_MIN_LEN)
                  && (i_frame_control[3:2] == dfd_pkg::TYPE_MGMT)
                  && ((i_frame_control[7:4] == dfd_pkg::SUB_DEAUTH)
                      || (i_frame_control[7:4] == dfd_pkg::SUB_DISASSOC));
        elapsed_inc = (r_elapsed != '1) ? r_elapsed + 16'd1 : r_elapsed;
        issue       = r_idx < r_used;

        ram_raddr = (r_state == S_IDLE) ? rd_off[AW-1:0] : r_idx[AW-1:0];
        ram_we    = (r_state == S_UPD) || ((r_state == S_ROLL) && r_pend);
        ram_waddr = (r_state == S_UPD) ? r_hit : r_cidx;
        ram_wdata = alu_res.entry;
        alu_in    = (r_state == S_UPD) ? r_ent : dfd_pkg::t_entry'(ram_rdata);
        any_next  = r_any | (r_pend & alu_res.entry.flood);

        fresh             = '0;
        fresh.bssid       = r_bssid;
        fresh.first_seen  = r_time;
        fresh.last_seen   = r_time;
    end

    dfd_ram #(
        .WIDTH (EW),
        .DEPTH (dfd_pkg::MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dfd_entry_alu u_alu (
        .i_entry     (alu_in),
        .i_roll      (r_state == S_ROLL),
        .i_threshold (r_thr),
        .i_time      (r_time),
        .i_bssid     (r_bssid),
        .o_res       (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_thr       <= dfd_pkg::THRESHOLD_RESET;
            r_wlen      <= dfd_pkg::WINDOW_RESET;
            r_used      <= '0;
            r_total     <= '0;
            r_flood_any <= 1'b0;
            r_time      <= '0;
            r_elapsed   <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_any       <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dfd_pkg::CFG_ENABLE:    r_enable <= i_cfg_wdata[0];
                    dfd_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_wdata;
                    dfd_pkg::CFG_WINDOW:    r_wlen   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_res_entry <= '0;
                        r_res_ev    <= 1'b0;
                        r_res_bf    <= 1'b0;
                        r_idx       <= '0;
                        r_pend      <= 1'b0;
                        r_any       <= 1'b0;
                        r_bssid     <= i_bssid_in;
                        case (i_op)
                            dfd_pkg::OP_FRAME: begin
                                if (qualify) begin
                                    if (r_total != '1) begin
                                        r_total <= r_total + 32'd1;
                                    end
                                    r_state <= S_SCAN;
                                end else begin
                                    r_valid <= 1'b1;
                                end
                            end
                            dfd_pkg::OP_TICK: begin
                                r_time <= r_time + 32'd1;
                                if (r_enable && (elapsed_inc >= r_wlen)) begin
                                    r_elapsed <= '0;
                                    r_state   <= S_ROLL;
                                end else begin
                                    r_elapsed <= r_enable ? elapsed_inc : 16'd0;
                                    r_valid   <= 1'b1;
                                end
                            end
                            dfd_pkg::OP_READ: begin
                                if (rd_hit) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_valid <= 1'b1;
                                end
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_res_entry <= dfd_pkg::t_entry'(ram_rdata);
                    r_res_ev    <= 1'b1;
                    r_valid     <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_pend && alu_res.match) begin
                        r_ent   <= dfd_pkg::t_entry'(ram_rdata);
                        r_hit   <= r_cidx;
                        r_pend  <= 1'b0;
                        r_state <= S_UPD;
                    end else if (issue) begin
                        r_cidx <= r_idx[AW-1:0];
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else if (r_used < CW'(dfd_pkg::MAX_ENTRIES)) begin
                        r_ent   <= fresh;
                        r_hit   <= r_used[AW-1:0];
                        r_used  <= r_used + CW'(1);
                        r_pend  <= 1'b0;
                        r_state <= S_UPD;
                    end else begin
                        r_pend  <= 1'b0;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_UPD: begin
                    r_res_entry <= alu_res.entry;
                    r_res_ev    <= 1'b1;
                    r_res_bf    <= alu_res.raised;
                    r_flood_any <= r_flood_any | alu_res.raised;
                    r_valid     <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_ROLL: begin
                    r_any <= any_next;
                    if (issue) begin
                        r_cidx <= r_idx[AW-1:0];
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_flood_any <= any_next;
                        r_pend      <= 1'b0;
                        r_valid     <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        busy             = (r_state != S_IDLE);
        o_valid          = r_valid;
        o_entry_valid    = r_res_ev;
        o_bssid_out      = r_res_entry.bssid;
        o_hit_count      = r_res_entry.hits;
        o_window_hits    = r_res_entry.window_hits;
        o_entry_flooding = r_res_entry.flood;
        o_first_seen_ms  = r_res_entry.first_seen;
        o_last_seen_ms   = r_res_entry.last_seen;
        o_became_flood   = r_res_bf;
        o_any_flooding   = r_flood_any;
        o_entries_used   = 9'(r_used);
        o_frames_total   = r_total;
    end

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(dfd_pkg::MAX_ENTRIES))
        else $error("table fill beyond capacity");

    a_transfer_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted transfer neither answered nor in progress");

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN || r_state == S_ROLL))
        else $error("table read in flight outside an entry walk");

endmodule

`default_nettype wire

[test/deauth_flood_detector_unit_tb.sv]
`timescale 1ns / 1ps

module deauth_flood_detector_unit_tb;

    localparam logic [1:0]  OP_FRAME        = dfd_pkg::OP_FRAME;
    localparam logic [1:0]  OP_TICK         = dfd_pkg::OP_TICK;
    localparam logic [1:0]  OP_READ         = dfd_pkg::OP_READ;
    localparam logic [1:0]  CFG_ENABLE      = dfd_pkg::CFG_ENABLE;
    localparam logic [1:0]  CFG_THRESHOLD   = dfd_pkg::CFG_THRESHOLD;
    localparam logic [1:0]  CFG_WINDOW      = dfd_pkg::CFG_WINDOW;
    localparam logic [15:0] THRESHOLD_RESET = dfd_pkg::THRESHOLD_RESET;
    localparam logic [15:0] WINDOW_RESET    = dfd_pkg::WINDOW_RESET;
    localparam logic [15:0] FRAME_MIN_LEN   = dfd_pkg::FRAME_MIN_LEN;
    localparam logic [1:0]  TYPE_MGMT       = dfd_pkg::TYPE_MGMT;
    localparam logic [3:0]  SUB_DEAUTH      = dfd_pkg::SUB_DEAUTH;
    localparam logic [3:0]  SUB_DISASSOC    = dfd_pkg::SUB_DISASSOC;
    localparam int          MAX_ENTRIES     = dfd_pkg::MAX_ENTRIES;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 135;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  frame_control;
        logic [15:0] frame_length;
        logic [47:0] bssid;
        logic [7:0]  read_index;
    } t_item;

    typedef struct packed {
        logic        entry_valid;
        logic [47:0] bssid;
        logic [31:0] hits;
        logic [15:0] window_hits;
        logic        flooding;
        logic [31:0] first_seen;
        logic [31:0] last_seen;
        logic        became_flood;
        logic        any_flooding;
        logic [8:0]  entries_used;
        logic [31:0] frames_total;
    } t_report;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  op;
        logic [7:0]  fc;
        logic [15:0] len;
        logic [47:0] bssid;
        logic [7:0]  ridx;
        logic [1:0]  cfg_idx;
        logic [15:0] cfg_val;
        logic        exp_any;
        logic [8:0]  exp_used;
        logic [31:0] exp_total;
    } t_dir_row;

    localparam int DIR_N = 29;
    // kind, op, fc, len, bssid, read index, reg, reg value, typed any / used / total
    localparam t_dir_row DIRECTED [DIR_N] = '{
        '{ROW_TYPED,   OP_READ,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_TYPED,   OP_READ,   8'h00, 16'd0,  48'h0, 8'd255, CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_TYPED,   OP_TICK,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_TYPED,   OP_UNUSED, 8'hC0, 16'd30, 48'h1, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        // still disabled
        '{ROW_TYPED,   OP_FRAME,  8'hC0, 16'd24, 48'h123456, 8'd0, CFG_ENABLE, 16'd0, 1'b0, 9'd0,
          32'd0},
        '{ROW_CFG,     OP_FRAME,  8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE,    16'd1, 1'b0, 9'd0,
          32'd0},
        '{ROW_CFG,     OP_FRAME,  8'h00, 16'd0,  48'h0, 8'd0,   CFG_THRESHOLD, 16'd2, 1'b0, 9'd0,
          32'd0},
        '{ROW_CFG,     OP_FRAME,  8'h00, 16'd0,  48'h0, 8'd0,   CFG_WINDOW,    16'd3, 1'b0, 9'd0,
          32'd0},
        // one byte short
        '{ROW_TYPED,   OP_FRAME,  8'hC0, 16'd23, 48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_FRAME,  8'hC0, 16'd24, 48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_FRAME,  8'hA0, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 8'd0, CFG_ENABLE, 16'd0,
          1'b0, 9'd0, 32'd0},
        // control, data and reserved types, then a non-matching subtype
        '{ROW_TYPED,   OP_FRAME,  8'hC4, 16'd100, 48'h0, 8'd0,  CFG_ENABLE, 16'd0, 1'b0, 9'd2, 32'd2},
        '{ROW_TYPED,   OP_FRAME,  8'hC8, 16'd100, 48'h0, 8'd0,  CFG_ENABLE, 16'd0, 1'b0, 9'd2, 32'd2},
        '{ROW_TYPED,   OP_FRAME,  8'hCC, 16'd100, 48'h0, 8'd0,  CFG_ENABLE, 16'd0, 1'b0, 9'd2, 32'd2},
        '{ROW_TYPED,   OP_FRAME,  8'hB0, 16'd100, 48'h0, 8'd0,  CFG_ENABLE, 16'd0, 1'b0, 9'd2, 32'd2},
        // second hit reaches the threshold
        '{ROW_PREDICT, OP_FRAME,  8'hC3, 16'd24, 48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_READ,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_READ,   8'h00, 16'd0,  48'h0, 8'd1,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_TYPED,   OP_READ,   8'h00, 16'd0,  48'h0, 8'd2,   CFG_ENABLE, 16'd0, 1'b1, 9'd2, 32'd3},
        '{ROW_PREDICT, OP_TICK,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_TICK,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_TICK,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_TICK,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_TICK,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        '{ROW_PREDICT, OP_TICK,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0},
        // zero threshold, then zero window
        '{ROW_CFG,     OP_FRAME,  8'h00, 16'd0,  48'h0, 8'd0,   CFG_THRESHOLD, 16'd0, 1'b0, 9'd0,
          32'd0},
        '{ROW_PREDICT, OP_FRAME,  8'hA3, 16'd24, 48'hFFFF_FFFF_FFFF, 8'd0, CFG_ENABLE, 16'd0,
          1'b0, 9'd0, 32'd0},
        '{ROW_CFG,     OP_FRAME,  8'h00, 16'd0,  48'h0, 8'd0,   CFG_WINDOW,    16'd0, 1'b0, 9'd0,
          32'd0},
        '{ROW_PREDICT, OP_TICK,   8'h00, 16'd0,  48'h0, 8'd0,   CFG_ENABLE, 16'd0, 1'b0, 9'd0, 32'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = OP_READ;
    logic [7:0]  i_frame_control = 8'h00;
    logic [15:0] i_frame_length = 16'h0000;
    logic [47:0] i_bssid_in = 48'h0;
    logic [7:0]  i_read_index = 8'h00;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_ENABLE;
    logic [15:0] i_cfg_wdata = 16'h0000;
    logic        o_valid;
    logic        o_entry_valid;
    logic [47:0] o_bssid_out;
    logic [31:0] o_hit_count;
    logic [15:0] o_window_hits;
    logic        o_entry_flooding;
    logic [31:0] o_first_seen_ms;
    logic [31:0] o_last_seen_ms;
    logic        o_became_flood;
    logic        o_any_flooding;
    logic [8:0]  o_entries_used;
    logic [31:0] o_frames_total;

    // predictor copy of the block state
    logic [47:0] tbl_bssid [MAX_ENTRIES];
    logic [31:0] tbl_hits  [MAX_ENTRIES];
    logic [15:0] tbl_win   [MAX_ENTRIES];
    logic        tbl_flag  [MAX_ENTRIES];
    logic [31:0] tbl_first [MAX_ENTRIES];
    logic [31:0] tbl_last  [MAX_ENTRIES];
    logic [4:0]  used_cnt = '0;
    logic [31:0] frame_count = '0;
    logic        any_flag = 1'b0;
    logic [31:0] now_ms = '0;
    logic [15:0] win_age = '0;
    logic        cfg_en = 1'b0;
    logic [15:0] cfg_thr = THRESHOLD_RESET;
    logic [15:0] cfg_win = WINDOW_RESET;

    t_report expected_reports [$];
    t_report want;
    t_report got;
    logic [47:0] bssid_pool [POOL_SIZE];
    int mismatches = 0;

    deauth_flood_detector_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_frame_control  (i_frame_control),
        .i_frame_length   (i_frame_length),
        .i_bssid_in       (i_bssid_in),
        .i_read_index     (i_read_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_entry_valid    (o_entry_valid),
        .o_bssid_out      (o_bssid_out),
        .o_hit_count      (o_hit_count),
        .o_window_hits    (o_window_hits),
        .o_entry_flooding (o_entry_flooding),
        .o_first_seen_ms  (o_first_seen_ms),
        .o_last_seen_ms   (o_last_seen_ms),
        .o_became_flood   (o_became_flood),
        .o_any_flooding   (o_any_flooding),
        .o_entries_used   (o_entries_used),
        .o_frames_total   (o_frames_total)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_report entry_report(input int slot);
        t_report r;
        r = '0;
        r.entry_valid = 1'b1;
        r.bssid = tbl_bssid[slot];
        r.hits = tbl_hits[slot];
        r.window_hits = tbl_win[slot];
        r.flooding = tbl_flag[slot];
        r.first_seen = tbl_first[slot];
        r.last_seen = tbl_last[slot];
        return r;
    endfunction

    function automatic t_report compute_report(input t_item s);
        t_report r;
        int slot;
        int i;
        logic still_any;
        logic raised;
        r = '0;
        raised = 1'b0;
        case (s.op)
            OP_FRAME: begin
                if (cfg_en && s.frame_length >= FRAME_MIN_LEN
                        && s.frame_control[3:2] == TYPE_MGMT
                        && (s.frame_control[7:4] == SUB_DEAUTH
                            || s.frame_control[7:4] == SUB_DISASSOC)) begin
                    if (frame_count != 32'hFFFF_FFFF) frame_count++;
                    slot = -1;
                    for (i = 0; i < int'(used_cnt); i++) begin
                        if (slot < 0 && tbl_bssid[i] == s.bssid) slot = i;
                    end
                    if (slot < 0 && int'(used_cnt) < MAX_ENTRIES) begin
                        slot = int'(used_cnt);
                        tbl_bssid[slot] = s.bssid;
                        tbl_hits[slot] = '0;
                        tbl_win[slot] = '0;
                        tbl_flag[slot] = 1'b0;
                        tbl_first[slot] = now_ms;
                        tbl_last[slot] = now_ms;
                        used_cnt++;
                    end
                    if (slot >= 0) begin
                        if (tbl_hits[slot] != 32'hFFFF_FFFF) tbl_hits[slot]++;
                        if (tbl_win[slot] != 16'hFFFF) tbl_win[slot]++;
                        tbl_last[slot] = now_ms;
                        if (!tbl_flag[slot] && tbl_win[slot] >= cfg_thr) begin
                            tbl_flag[slot] = 1'b1;
                            any_flag = 1'b1;
                            raised = 1'b1;
                        end
                        r = entry_report(slot);
                    end
                end
            end
            OP_TICK: begin
                now_ms++;
                if (cfg_en) begin
                    if (win_age != 16'hFFFF) win_age++;
                    if (win_age >= cfg_win) begin
                        still_any = 1'b0;
                        for (i = 0; i < int'(used_cnt); i++) begin
                            if (tbl_win[i] < cfg_thr) tbl_flag[i] = 1'b0;
                            tbl_win[i] = '0;
                            if (tbl_flag[i]) still_any = 1'b1;
                        end
                        any_flag = still_any;
                        win_age = '0;
                    end
                end else begin
                    win_age = '0;
                end
            end
            OP_READ: begin
                if (int'(s.read_index) < int'(used_cnt))
                    r = entry_report(int'(used_cnt) - 1 - int'(s.read_index));
            end
            default: begin
            end
        endcase
        r.became_flood = raised;
        r.any_flooding = any_flag;
        r.entries_used = 9'(used_cnt);
        r.frames_total = frame_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [47:0] exp_v,
                               input logic [47:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            got = '{o_entry_valid, o_bssid_out, o_hit_count, o_window_hits, o_entry_flooding,
                    o_first_seen_ms, o_last_seen_ms, o_became_flood, o_any_flooding,
                    o_entries_used, o_frames_total};
            if (expected_reports.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, got %0h", $time, got);
            end else begin
                want = expected_reports.pop_front();
                check_field("entry_valid", want.entry_valid, got.entry_valid);
                check_field("bssid_out", want.bssid, got.bssid);
                check_field("hit_count", want.hits, got.hits);
                check_field("window_hits", want.window_hits, got.window_hits);
                check_field("entry_flooding", want.flooding, got.flooding);
                check_field("first_seen_ms", want.first_seen, got.first_seen);
                check_field("last_seen_ms", want.last_seen, got.last_seen);
                check_field("became_flood", want.became_flood, got.became_flood);
                check_field("any_flooding", want.any_flooding, got.any_flooding);
                check_field("entries_used", want.entries_used, got.entries_used);
                check_field("frames_total", want.frames_total, got.frames_total);
            end
        end
    end

    // start stays high until the transfer happens
    task automatic send_item(input t_item it, input logic use_typed,
                             input t_report typed);
        t_report pred;
        start <= 1'b1;
        i_op <= it.op;
        i_frame_control <= it.frame_control;
        i_frame_length <= it.frame_length;
        i_bssid_in <= it.bssid;
        i_read_index <= it.read_index;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = compute_report(it);
        expected_reports = {expected_reports, (use_typed ? typed : pred)};
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:    cfg_en = val[0];
            CFG_THRESHOLD: cfg_thr = val;
            CFG_WINDOW:    cfg_win = val;
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_item next_random_item();
        t_item it;
        int pick;
        it.op = 2'($urandom_range(0, 3));
        it.frame_control = 8'($urandom);
        it.frame_length = 16'($urandom);
        it.bssid = {16'($urandom), 32'($urandom)};
        it.read_index = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.op = OP_FRAME;
            it.frame_control[7:4] = $urandom_range(0, 1) ? SUB_DEAUTH : SUB_DISASSOC;
            it.frame_control[3:2] = TYPE_MGMT;
            it.frame_length = 16'($urandom_range(int'(FRAME_MIN_LEN), 16'hFFFF));
            // a few sources dominate so windows can reach the threshold
            if (pick < 25)
                it.bssid = bssid_pool[$urandom_range(0, 2)];
            else if (pick < 47)
                it.bssid = bssid_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 60) begin
            it.op = OP_FRAME;
        end else if (pick < 82) begin
            it.op = OP_TICK;
        end else if (pick < 96) begin
            it.op = OP_READ;
            if ($urandom_range(0, 3) != 0) it.read_index = 8'($urandom_range(0, 20));
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    initial begin
        t_dir_row row;
        t_item it;
        t_report typed;
        int k;
        int p;
        int n;
        int idle_pct;
        logic [15:0] thr;
        logic [15:0] win;
        logic en;

        for (k = 0; k < POOL_SIZE; k++) bssid_pool[k] = {16'($urandom), 32'($urandom)};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_N; k++) begin
            row = DIRECTED[k];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.cfg_idx, row.cfg_val);
            end else begin
                it = '{row.op, row.fc, row.len, row.bssid, row.ridx};
                typed = '0;
                typed.any_flooding = row.exp_any;
                typed.entries_used = row.exp_used;
                typed.frames_total = row.exp_total;
                send_item(it, row.kind == ROW_TYPED, typed);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            en = 1'b1;
            case (p)
                0: begin thr = 16'd3; win = 16'd20; idle_pct = 0; end
                1: begin thr = 16'd1; win = 16'd1; idle_pct = 54; end
                2: begin
                    en = 1'b0;
                    thr = 16'($urandom);
                    win = 16'($urandom);
                    idle_pct = 23;
                end
                3: begin thr = 16'hFFFF; win = 16'hFFFF; idle_pct = 0; end
                4: begin thr = 16'd5; win = 16'd50; idle_pct = 54; end
                5: begin thr = 16'd0; win = 16'd0; idle_pct = 23; end
                6: begin
                    thr = 16'($urandom_range(2, 6));
                    win = 16'($urandom_range(5, 40));
                    idle_pct = 0;
                end
                default: begin thr = 16'd2; win = 16'd8; idle_pct = 54; end
            endcase
            settle();
            write_reg(CFG_ENABLE, {15'd0, en});
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_WINDOW, win);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_item(next_random_item(), 1'b0, '0);
                if ($urandom_range(0, 99) < idle_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end
            end
        end

        settle();
        repeat (25) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
src/dfd_pkg.sv
src/dfd_ram.sv
src/dfd_entry_alu.sv
src/deauth_flood_detector_unit.sv
test/deauth_flood_detector_unit_tb.sv
